### rtl/core/t2tbm_pkg.sv
// Shared types, constants and codes for the Type 2 tag block memory.
package t2tbm_pkg;

  // Store geometry
  localparam int MEM_BYTES         = 1024;
  localparam int BLOCKS_PER_SECTOR = 256;
  localparam int BLOCK_BYTES       = 4;
  localparam int WORDS_PER_READ    = 4;
  localparam int MEM_WORDS         = MEM_BYTES / BLOCK_BYTES;
  localparam int WADDR_W           = $clog2(MEM_WORDS);
  localparam int K_W               = $clog2(WORDS_PER_READ);

  // Field widths
  localparam int CMD_W    = 2;
  localparam int BLOCK_W  = 8;
  localparam int SECTOR_W = 8;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 3;
  localparam int USED_W   = 11;

  // Block index (sector * blocks per sector + block) and byte address widths
  localparam int BLK_IDX_W = $clog2(((1 << SECTOR_W) - 1) * BLOCKS_PER_SECTOR + (1 << BLOCK_W));
  localparam int ADDR_W    = BLK_IDX_W + 2;
  localparam int FRONT_A_W = (ADDR_W > USED_W) ? ADDR_W : USED_W;
  localparam int FRONT_W   = ((FRONT_A_W > WADDR_W + 2) ? FRONT_A_W : WADDR_W + 2) + 1;
  localparam int RBYTE_W   = WADDR_W + 3;
  localparam int BACK_W    = ((RBYTE_W > USED_W) ? RBYTE_W : USED_W) + 1;

  // Tag layout
  localparam int CC_ACCESS_BYTE = 15;
  localparam int LOCK_WORD      = 2;
  localparam int CC_WORD        = 3;
  localparam int LOCK_BLOCK     = 2;
  localparam int CC_BLOCK       = 3;
  localparam int UID_BLOCKS     = 2;
  localparam logic [7:0] TERMINATOR = 8'hFE;
  // lock bytes 10..11 sit in the low half of word 2 (byte enables 2 and 3)
  localparam logic [BLOCK_BYTES-1:0] LOCK_BE = 4'b1100;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Register file
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_USED_BYTES = '0;
  localparam logic [USED_W-1:0]    USED_RESET     = 11'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_SECTOR = 2'd2,
    CMD_LOAD   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_RANGE     = 3'd1,
    STS_READ_ONLY = 3'd2,
    STS_UID       = 3'd3,
    STS_SECTOR    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_READ,
    OP_STORE,
    OP_CC_OR,
    OP_LOCK_OR,
    OP_REPLY
  } op_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [BLOCK_W-1:0]  block_number;
    logic [WORD_W-1:0]   write_word;
    logic [SECTOR_W-1:0] sector_number;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   data_word;
    logic                last;
  } out_item_t;

  typedef struct packed {
    op_e                    op;
    status_e                status;
    logic                   chk_ro;
    logic [WADDR_W-1:0]     waddr;
    logic [BLOCK_BYTES-1:0] byte_en;
    logic [WORD_W-1:0]      wdata;
  } queue_entry_t;

endpackage

### rtl/core/t2tbm_front.sv
// Front end: accepts items, tracks the sector, classifies each command.
module t2tbm_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  t2tbm_pkg::in_item_t            in_item_i,
  input  logic [t2tbm_pkg::USED_W-1:0]   used_i,
  input  logic                           clearing_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output t2tbm_pkg::queue_entry_t        q_entry_o
);
  import t2tbm_pkg::*;

  logic [SECTOR_W-1:0]    sector_q, sector_d;
  logic [BLK_IDX_W-1:0]   blk_idx;
  logic [FRONT_W-1:0]     addr, used_ext, sec_base;
  logic [BLOCK_BYTES-1:0] byte_en;
  logic                   in_range, sector0, accept;
  cmd_e                   cmd;

  // Handshake: hold off while the queue is full or the store is being cleared
  assign in_stall_o = q_full_i | clearing_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign q_push_o   = accept;

  // Address arithmetic
  assign blk_idx  = BLK_IDX_W'(sector_q) * BLK_IDX_W'(BLOCKS_PER_SECTOR)
                  + BLK_IDX_W'(in_item_i.block_number);
  assign addr     = FRONT_W'({blk_idx, 2'b00});
  assign used_ext = FRONT_W'(used_i);
  assign sec_base = FRONT_W'(BLK_IDX_W'(in_item_i.sector_number)
                  * BLK_IDX_W'(BLOCKS_PER_SECTOR));
  assign in_range = addr < used_ext;
  assign sector0  = (sector_q == '0);
  assign cmd      = cmd_e'(in_item_i.command);

  // Bytes of a block that fall below the used size
  always_comb begin
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      byte_en[i] = (addr + FRONT_W'(i)) < used_ext;
    end
  end

  // Command classification
  always_comb begin
    q_entry_o         = '0;
    q_entry_o.op      = OP_REPLY;
    q_entry_o.status  = STS_OK;
    q_entry_o.waddr   = addr[WADDR_W+1:2];
    q_entry_o.byte_en = byte_en;
    q_entry_o.wdata   = in_item_i.write_word;
    sector_d          = sector_q;
    unique case (cmd)
      CMD_READ: begin
        if (!in_range) begin
          q_entry_o.status = STS_RANGE;
        end else begin
          q_entry_o.op = OP_READ;
        end
      end
      CMD_WRITE: begin
        // read-only check itself is done in order by the back end
        q_entry_o.chk_ro = used_ext > FRONT_W'(CC_ACCESS_BYTE);
        if (!in_range) begin
          q_entry_o.status = STS_RANGE;
        end else if (sector0 && in_item_i.block_number == BLOCK_W'(CC_BLOCK)) begin
          q_entry_o.op    = OP_CC_OR;
          q_entry_o.waddr = WADDR_W'(CC_WORD);
        end else if (sector0 && in_item_i.block_number == BLOCK_W'(LOCK_BLOCK)) begin
          q_entry_o.op    = OP_LOCK_OR;
          q_entry_o.waddr = WADDR_W'(LOCK_WORD);
        end else if (sector0 && in_item_i.block_number < BLOCK_W'(UID_BLOCKS)) begin
          q_entry_o.status = STS_UID;
        end else begin
          q_entry_o.op = OP_STORE;
        end
      end
      CMD_SECTOR: begin
        if (used_ext < sec_base) begin
          q_entry_o.status = STS_SECTOR;
        end else begin
          sector_d = in_item_i.sector_number;
        end
      end
      CMD_LOAD: begin
        if (!in_range) begin
          q_entry_o.status = STS_RANGE;
        end else begin
          q_entry_o.op = OP_STORE;
        end
      end
    endcase
  end

  // Selected sector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_q <= '0;
    end else if (accept) begin
      sector_q <= sector_d;
    end
  end

endmodule

### rtl/core/t2tbm_fifo.sv
// Short queue of classified commands between front and back end.
module t2tbm_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  t2tbm_pkg::queue_entry_t entry_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output logic                    empty_o,
  output t2tbm_pkg::queue_entry_t head_o
);
  import t2tbm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t      slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/core/t2tbm_back.sv
// Back end: word store, clearing pass, protection rules and result register.
module t2tbm_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [t2tbm_pkg::USED_W-1:0] used_i,
  input  logic                         q_empty_i,
  input  t2tbm_pkg::queue_entry_t      q_entry_i,
  output logic                         q_pop_o,
  output logic                         clearing_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output t2tbm_pkg::out_item_t         out_item_o
);
  import t2tbm_pkg::*;

  back_state_e            state_q, state_d;
  logic [WADDR_W-1:0]     clr_q, clr_d;
  logic [WADDR_W-1:0]     base_q, base_d;
  logic [K_W-1:0]         k_q, k_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  logic [WORD_W-1:0]      mem_q [MEM_WORDS];
  logic [WORD_W-1:0]      rd_q;
  logic [WORD_W-1:0]      lock_word_q, cc_word_q;

  logic                   mem_we, mem_re;
  logic [WADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [BLOCK_BYTES-1:0] mem_be;
  logic [WORD_W-1:0]      mem_wdata;

  logic                   out_free, tag_locked, last_word;
  logic [BACK_W-1:0]      rd_byte_addr;
  logic [WORD_W-1:0]      rd_word;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign tag_locked  = q_entry_i.chk_ro && (cc_word_q[7:0] != '0);
  assign last_word   = (k_q == K_W'(WORDS_PER_READ - 1));
  assign clearing_o  = (state_q == BK_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Read data with bytes past the used size replaced by the terminator
  assign rd_byte_addr = (BACK_W'(base_q) + BACK_W'(k_q)) << 2;
  always_comb begin
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      rd_word[WORD_W-1-8*i -: 8] =
        ((rd_byte_addr + BACK_W'(i)) < BACK_W'(used_i)) ? rd_q[WORD_W-1-8*i -: 8] : TERMINATOR;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_CLEAR: begin
        if (clr_q == WADDR_W'(MEM_WORDS - 1)) state_d = BK_IDLE;
      end
      BK_IDLE: begin
        if (!q_empty_i && q_entry_i.op == OP_READ) state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free && last_word) state_d = BK_IDLE;
      end
      default: state_d = BK_CLEAR;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = q_entry_i.waddr;
    mem_be      = q_entry_i.byte_en;
    mem_wdata   = q_entry_i.wdata;
    mem_re      = 1'b0;
    mem_raddr   = q_entry_i.waddr;
    clr_d       = clr_q;
    base_d      = base_q;
    k_d         = k_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_be    = '1;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      BK_IDLE: begin
        if (!q_empty_i) begin
          if (q_entry_i.op == OP_READ) begin
            // fetch the first word; results go out from the emit state
            q_pop_o = 1'b1;
            mem_re  = 1'b1;
            base_d  = q_entry_i.waddr;
            k_d     = '0;
          end else if (out_free) begin
            q_pop_o         = 1'b1;
            out_valid_d     = 1'b1;
            out_d.status    = tag_locked ? STS_READ_ONLY : q_entry_i.status;
            out_d.data_word = '0;
            out_d.last      = 1'b1;
            if (!tag_locked) begin
              case (q_entry_i.op)
                OP_STORE: mem_we = 1'b1;
                OP_CC_OR: begin
                  mem_we    = 1'b1;
                  mem_be    = '1;
                  mem_wdata = cc_word_q | q_entry_i.wdata;
                end
                OP_LOCK_OR: begin
                  // word bytes 2..3 land on lock bytes 10..11
                  mem_we    = 1'b1;
                  mem_be    = LOCK_BE;
                  mem_wdata = lock_word_q | q_entry_i.wdata;
                end
                default: ;
              endcase
            end
          end
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.status    = STS_OK;
          out_d.data_word = rd_word;
          out_d.last      = last_word;
          if (!last_word) begin
            k_d       = k_q + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = base_q + WADDR_W'(k_q) + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Word store with byte enables, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int i = 0; i < BLOCK_BYTES; i++) begin
        if (mem_be[i]) mem_q[mem_waddr][WORD_W-1-8*i -: 8] <= mem_wdata[WORD_W-1-8*i -: 8];
      end
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  // Copies of the lock and CC words for the OR updates and read-only check
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_word_q <= '0;
      cc_word_q   <= '0;
    end else if (mem_we) begin
      for (int i = 0; i < BLOCK_BYTES; i++) begin
        if (mem_be[i] && mem_waddr == WADDR_W'(LOCK_WORD)) begin
          lock_word_q[WORD_W-1-8*i -: 8] <= mem_wdata[WORD_W-1-8*i -: 8];
        end
        if (mem_be[i] && mem_waddr == WADDR_W'(CC_WORD)) begin
          cc_word_q[WORD_W-1-8*i -: 8] <= mem_wdata[WORD_W-1-8*i -: 8];
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_q       <= '0;
      base_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      base_q      <= base_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

### rtl/core/type2_tag_block_memory.sv
// Top level of the Type 2 tag block memory: register port, front, queue, back.
// Non-read commands: result via the queue and the result register; one per cycle while
// the output is not stalled and no read is emitting. Read: four results, one per word.
// The front queues one item per cycle (two-entry queue) while the back works, unless full.
// Reset: used_bytes to 64, sector 0, then a clearing pass of the whole store
//   (one word a cycle) with in_stall_o high; register writes are taken meanwhile.
module type2_tag_block_memory (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  t2tbm_pkg::in_item_t             in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output t2tbm_pkg::out_item_t            out_item_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [t2tbm_pkg::PADDR_W-1:0]   paddr,
  input  logic [t2tbm_pkg::PDATA_W-1:0]   pwdata,
  output logic [t2tbm_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready
);
  import t2tbm_pkg::*;

  logic [USED_W-1:0]    used_bytes_q, used;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 clearing, q_push, q_full, q_pop, q_empty;
  queue_entry_t         q_entry, q_head;

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign prdata  = (reg_idx == REG_USED_BYTES) ? PDATA_W'(used_bytes_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_bytes_q <= USED_RESET;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_USED_BYTES) begin
      used_bytes_q <= pwdata[USED_W-1:0];
    end
  end

  // Used size, capped at the store size
  always_comb begin
    if (int'(used_bytes_q) > MEM_BYTES) begin
      used = USED_W'(MEM_BYTES);
    end else begin
      used = used_bytes_q;
    end
  end

  t2tbm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .used_i     (used),
    .clearing_i (clearing),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  t2tbm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  t2tbm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .used_i      (used),
    .q_empty_i   (q_empty),
    .q_entry_i   (q_head),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef NO_ASSERTIONS
  a_quiet_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !out_valid_o)
    else $error("result presented during clearing pass");

  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("push into full command queue");

  a_error_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status != STS_OK) |->
      (out_item_o.last && out_item_o.data_word == '0))
    else $error("error result not a single zero-data item");

  a_burst_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.last) |-> (out_item_o.status == STS_OK))
    else $error("non-final read word with error status");
`endif

endmodule
